/* src/lbsbe_pkg.sv */
// Shared types, constants and coefficient tables for the Loop patch basis evaluator.
// Used by lbsbe_pipe_ctrl and loop_box_spline_basis_eval. No dependencies.
`timescale 1ns / 1ps

package lbsbe_pkg;

    localparam int DEF_FRAC_BITS = 15;

    localparam int COORD_W     = 16;
    localparam int WEIGHT_W    = 16;
    localparam int NUM_WEIGHTS = 12;
    localparam int NUM_PAIRS   = 6;
    localparam int NUM_MONOS   = 15;

    localparam int PAIR_W = 2 * COORD_W;
    localparam int MONO_W = 2 * PAIR_W;
    // coefficient sums stay below 2^9, so a weighted sum fits in 73 bits
    localparam int ACC_W  = MONO_W + 9;
    // monomials below this index go to the first partial sum
    localparam int SPLIT  = 8;

    // divide by 3 through a reciprocal; exact for arguments below 2^RECIP_SH
    localparam int QUO_W    = 18;
    localparam int RECIP_SH = 19;
    localparam int RECIP_W  = 18;
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(174763);
    localparam int PROD_W   = QUO_W + RECIP_W;

    // pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int ST_PAIR    = 0;
    localparam int ST_MONO    = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_SCALE   = 3;
    localparam int ST_OUT     = 4;

    // degree-2 products of the coordinates
    localparam logic [2:0] PAIR_UU = 3'd0;
    localparam logic [2:0] PAIR_VV = 3'd1;
    localparam logic [2:0] PAIR_WW = 3'd2;
    localparam logic [2:0] PAIR_UV = 3'd3;
    localparam logic [2:0] PAIR_UW = 3'd4;
    localparam logic [2:0] PAIR_VW = 3'd5;

    // degree-4 monomials, ordered u^4, u^3v, u^3w, u^2v^2, u^2vw, u^2w^2, uv^3, uv^2w,
    // uvw^2, uw^3, v^4, v^3w, v^2w^2, vw^3, w^4; each is MONO_A * MONO_B
    localparam logic [2:0] MONO_A [NUM_MONOS] = '{
        PAIR_UU, PAIR_UU, PAIR_UU, PAIR_UU, PAIR_UU, PAIR_UU, PAIR_UV, PAIR_UV,
        PAIR_UW, PAIR_UW, PAIR_VV, PAIR_VV, PAIR_VV, PAIR_VW, PAIR_WW
    };
    localparam logic [2:0] MONO_B [NUM_MONOS] = '{
        PAIR_UU, PAIR_UV, PAIR_UW, PAIR_VV, PAIR_VW, PAIR_WW, PAIR_VV, PAIR_VW,
        PAIR_VW, PAIR_WW, PAIR_VV, PAIR_VW, PAIR_WW, PAIR_WW, PAIR_WW
    };

    // integer coefficients (times 1/12) of each weight over the monomials above
    localparam logic [5:0] COEF [NUM_WEIGHTS][NUM_MONOS] = '{
        '{6'd1, 6'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
          6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd0, 6'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
          6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd2, 6'd12, 6'd6, 6'd0, 6'd6, 6'd6,
          6'd0, 6'd0, 6'd1, 6'd2, 6'd0, 6'd0, 6'd0},
        '{6'd6, 6'd24, 6'd24, 6'd24, 6'd60, 6'd24, 6'd8, 6'd36,
          6'd36, 6'd8, 6'd1, 6'd6, 6'd12, 6'd6, 6'd1},
        '{6'd1, 6'd2, 6'd6, 6'd0, 6'd6, 6'd12, 6'd0, 6'd0,
          6'd6, 6'd6, 6'd0, 6'd0, 6'd0, 6'd2, 6'd1},
        '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd2, 6'd0,
          6'd0, 6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0},
        '{6'd1, 6'd8, 6'd6, 6'd24, 6'd36, 6'd12, 6'd24, 6'd60,
          6'd36, 6'd6, 6'd6, 6'd24, 6'd24, 6'd8, 6'd1},
        '{6'd1, 6'd6, 6'd8, 6'd12, 6'd36, 6'd24, 6'd6, 6'd36,
          6'd60, 6'd24, 6'd1, 6'd8, 6'd24, 6'd24, 6'd6},
        '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
          6'd0, 6'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1},
        '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
          6'd0, 6'd0, 6'd1, 6'd2, 6'd0, 6'd0, 6'd0},
        '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd2, 6'd6,
          6'd6, 6'd2, 6'd1, 6'd6, 6'd12, 6'd6, 6'd1},
        '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
          6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd2, 6'd1}
    };

    typedef struct packed {
        logic [COORD_W-1:0] bary_v;
        logic [COORD_W-1:0] bary_w;
        logic [COORD_W-1:0] bary_u;
    } point_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_0;
        logic [WEIGHT_W-1:0] weight_1;
        logic [WEIGHT_W-1:0] weight_2;
        logic [WEIGHT_W-1:0] weight_3;
        logic [WEIGHT_W-1:0] weight_4;
        logic [WEIGHT_W-1:0] weight_5;
        logic [WEIGHT_W-1:0] weight_6;
        logic [WEIGHT_W-1:0] weight_7;
        logic [WEIGHT_W-1:0] weight_8;
        logic [WEIGHT_W-1:0] weight_9;
        logic [WEIGHT_W-1:0] weight_10;
        logic [WEIGHT_W-1:0] weight_11;
    } weights_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
        logic                  in_ready;
    } pipe_ctrl_t;

endpackage

/* src/loop_box_spline_basis_eval.sv */
// Top level of the regular Loop patch basis evaluator (quartic box-spline weights).
// Depends on lbsbe_pkg and lbsbe_pipe_ctrl.
`timescale 1ns / 1ps

// Usage
// -----
// Input channel "point" (point_valid / point_ready / point) carries one barycentric
// coordinate triple (v, w, u), unsigned Q1.FRAC_BITS. Output channel "weights"
// (weights_valid / weights_ready / weights) carries the twelve basis weights of the
// one-ring vertices, rounded to nearest, saturated to 1.0 (or 0xFFFF if 1.0 does not
// fit in 16 bits). One result transaction per input transaction, in order.
//
// Throughput: one transaction per cycle while the receiver does not stall. Five register
// stages, the first loaded at the accepting edge: coordinate pair products (16x16),
// degree-4 monomials (32x32), two partial weighted sums per weight, rounding/saturation
// check with divide-by-4, and divide-by-3 via reciprocal multiply with clamp.
//
// Each stage holds a valid bit and loads whenever it is empty or its content moves
// on, so when the receiver stalls the output register holds its result while
// earlier stages keep filling; point_ready drops only once all five are full.
// Reset clears the valid bits only; no result is presented after reset until a
// new point is accepted.

module loop_box_spline_basis_eval
    import lbsbe_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     point_valid,
    output logic     point_ready,
    input  point_t   point,
    output logic     weights_valid,
    input  logic     weights_ready,
    output weights_t weights
);

    // rounding works on the exact sum scaled by 2^(3F)
    localparam int SH     = 3 * FRAC_BITS;
    localparam int TSUM_W = (SH + 4 > ACC_W + 1) ? (SH + 4) : (ACC_W + 1);
    localparam logic [TSUM_W-1:0] HALF = TSUM_W'(6) << SH;
    localparam logic [WEIGHT_W-1:0] CAP =
        (FRAC_BITS < WEIGHT_W) ? WEIGHT_W'(1 << FRAC_BITS) : {WEIGHT_W{1'b1}};
    // quotient by 12 exceeds CAP exactly when q reaches 12 * (CAP + 1)
    localparam int unsigned Q_LIM = 12 * (int'(CAP) + 1);

    pipe_ctrl_t ctrl;

    lbsbe_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point_valid),
        .out_ready (weights_ready),
        .ctrl      (ctrl)
    );

    assign point_ready   = ctrl.in_ready;
    assign weights_valid = ctrl.valid[ST_OUT];

    // stage 1: degree-2 products
    logic [PAIR_W-1:0] pair_reg  [NUM_PAIRS];
    logic [PAIR_W-1:0] pair_next [NUM_PAIRS];

    always_comb
    begin
        pair_next[PAIR_UU] = PAIR_W'(point.bary_u) * PAIR_W'(point.bary_u);
        pair_next[PAIR_VV] = PAIR_W'(point.bary_v) * PAIR_W'(point.bary_v);
        pair_next[PAIR_WW] = PAIR_W'(point.bary_w) * PAIR_W'(point.bary_w);
        pair_next[PAIR_UV] = PAIR_W'(point.bary_u) * PAIR_W'(point.bary_v);
        pair_next[PAIR_UW] = PAIR_W'(point.bary_u) * PAIR_W'(point.bary_w);
        pair_next[PAIR_VW] = PAIR_W'(point.bary_v) * PAIR_W'(point.bary_w);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_PAIR])
        begin
            pair_reg <= pair_next;
        end
    end

    // stage 2: degree-4 monomials
    logic [MONO_W-1:0] mono_reg  [NUM_MONOS];
    logic [MONO_W-1:0] mono_next [NUM_MONOS];

    always_comb
    begin
        for (int m = 0; m < NUM_MONOS; m++)
        begin
            mono_next[m] = MONO_W'(pair_reg[MONO_A[m]]) * MONO_W'(pair_reg[MONO_B[m]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_MONO])
        begin
            mono_reg <= mono_next;
        end
    end

    // stage 3: two partial weighted sums per weight (constant coefficients)
    logic [ACC_W-1:0] psum_a_reg  [NUM_WEIGHTS];
    logic [ACC_W-1:0] psum_b_reg  [NUM_WEIGHTS];
    logic [ACC_W-1:0] psum_a_next [NUM_WEIGHTS];
    logic [ACC_W-1:0] psum_b_next [NUM_WEIGHTS];

    always_comb
    begin
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            psum_a_next[k] = '0;
            psum_b_next[k] = '0;
            for (int m = 0; m < NUM_MONOS; m++)
            begin
                if (m < SPLIT)
                begin
                    psum_a_next[k] = psum_a_next[k]
                                   + ACC_W'(COEF[k][m]) * ACC_W'(mono_reg[m]);
                end
                else
                begin
                    psum_b_next[k] = psum_b_next[k]
                                   + ACC_W'(COEF[k][m]) * ACC_W'(mono_reg[m]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_SUM])
        begin
            psum_a_reg <= psum_a_next;
            psum_b_reg <= psum_b_next;
        end
    end

    // stage 4: add rounding offset, drop 3F fraction bits, saturation check
    logic              sat_reg  [NUM_WEIGHTS];
    logic              sat_next [NUM_WEIGHTS];
    logic [QUO_W-1:0]  quo_reg  [NUM_WEIGHTS];
    logic [QUO_W-1:0]  quo_next [NUM_WEIGHTS];
    logic [TSUM_W-1:0] tsum     [NUM_WEIGHTS];
    logic [TSUM_W-1:0] qsh      [NUM_WEIGHTS];

    always_comb
    begin
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            tsum[k]     = TSUM_W'(psum_a_reg[k]) + TSUM_W'(psum_b_reg[k]) + HALF;
            qsh[k]      = tsum[k] >> SH;
            sat_next[k] = (qsh[k] >= TSUM_W'(Q_LIM));
            // q / 12 = (q / 4) / 3; only meaningful below Q_LIM
            quo_next[k] = qsh[k][QUO_W+1:2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_SCALE])
        begin
            sat_reg <= sat_next;
            quo_reg <= quo_next;
        end
    end

    // stage 5: divide by 3 via reciprocal, clamp, output register
    logic [WEIGHT_W-1:0] wt_reg  [NUM_WEIGHTS];
    logic [WEIGHT_W-1:0] wt_next [NUM_WEIGHTS];
    logic [PROD_W-1:0]   div_prod [NUM_WEIGHTS];

    always_comb
    begin
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            div_prod[k] = PROD_W'(quo_reg[k]) * PROD_W'(RECIP3);
            wt_next[k]  = sat_reg[k] ? CAP : WEIGHT_W'(div_prod[k] >> RECIP_SH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_OUT])
        begin
            wt_reg <= wt_next;
        end
    end

    always_comb
    begin
        weights.weight_0  = wt_reg[0];
        weights.weight_1  = wt_reg[1];
        weights.weight_2  = wt_reg[2];
        weights.weight_3  = wt_reg[3];
        weights.weight_4  = wt_reg[4];
        weights.weight_5  = wt_reg[5];
        weights.weight_6  = wt_reg[6];
        weights.weight_7  = wt_reg[7];
        weights.weight_8  = wt_reg[8];
        weights.weight_9  = wt_reg[9];
        weights.weight_10 = wt_reg[10];
        weights.weight_11 = wt_reg[11];
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    logic wt_in_range;

    always_comb
    begin
        wt_in_range = 1'b1;
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            if (wt_reg[k] > CAP)
            begin
                wt_in_range = 1'b0;
            end
        end
    end

    // the divide path must never produce a weight above the clamp value
    a_weight_capped: assert property (@(posedge clk) disable iff (!rst_n)
        weights_valid |-> wt_in_range)
        else $error("weight above saturation limit");

    // at most one transaction enters the pipeline per cycle
    a_fill_rate: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(ctrl.valid) <= $past($countones(ctrl.valid)) + 1)
        else $error("pipeline occupancy grew by more than one");

    // a full pipeline with a stalled receiver must refuse new points
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        ((&ctrl.valid) && !weights_ready) |-> !point_ready)
        else $error("point accepted while pipeline full and stalled");

endmodule

/* src/lbsbe_pipe_ctrl.sv */
// Valid/ready control of the evaluator pipeline: per-stage valid bits and load enables.
// Depends on lbsbe_pkg.
`timescale 1ns / 1ps

module lbsbe_pipe_ctrl
    import lbsbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    // a stage takes new data when empty or when its content moves on
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        ctrl.load     = ready;
        ctrl.valid    = valid_reg;
        ctrl.in_ready = ready[0];
    end

endmodule
